// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// overlapping implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/oas_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oas_pkg
// Types, register map and constants of the obstacle avoidance steering unit
// ---------------------------------------------------------------------------
package oas_pkg;

  localparam int SENSOR_BITS_DEF = 12;
  localparam int FIELD_BITS      = 12;
  localparam int GAIN_BITS       = 5;
  localparam int SPEED_BITS      = 10;

  localparam int APB_ADDR_BITS   = 5;
  localparam int APB_DATA_BITS   = 32;

  // register indexes
  localparam logic [2:0] REG_DETECT_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_CRUISE_SPEED     = 3'd1;
  localparam logic [2:0] REG_STEER_LIMIT      = 3'd2;
  localparam logic [2:0] REG_GAIN_SIDE        = 3'd3;
  localparam logic [2:0] REG_GAIN_DIAG        = 3'd4;
  localparam logic [2:0] REG_GAIN_FRONT       = 3'd5;

  localparam logic [FIELD_BITS-1:0] DETECT_THRESHOLD_RST = 12'd100;
  localparam logic [SPEED_BITS-1:0] CRUISE_SPEED_RST     = 10'd150;
  localparam logic [SPEED_BITS-1:0] STEER_LIMIT_RST      = 10'd600;
  localparam logic [GAIN_BITS-1:0]  GAIN_SIDE_RST        = 5'd2;
  localparam logic [GAIN_BITS-1:0]  GAIN_DIAG_RST        = 5'd9;
  localparam logic [GAIN_BITS-1:0]  GAIN_FRONT_RST       = 5'd12;

  // latched obstacle side codes
  localparam logic [1:0] SIDE_NONE  = 2'd0;
  localparam logic [1:0] SIDE_LEFT  = 2'd1;
  localparam logic [1:0] SIDE_RIGHT = 2'd2;

  // sensor term index within a side
  localparam int TERM_SIDE  = 0;
  localparam int TERM_DIAG  = 1;
  localparam int TERM_FRONT = 2;

  typedef struct packed {
    logic [FIELD_BITS-1:0] right_front;
    logic [FIELD_BITS-1:0] right_diag;
    logic [FIELD_BITS-1:0] right_side;
    logic [FIELD_BITS-1:0] left_side;
    logic [FIELD_BITS-1:0] left_diag;
    logic [FIELD_BITS-1:0] left_front;
    logic                  clear_request;
  } sensor_word_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] left_wheel;
    logic signed [FIELD_BITS-1:0] right_wheel;
    logic                         avoiding;
    logic [1:0]                   obstacle_side;
  } steer_word_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] detect_threshold;
    logic [SPEED_BITS-1:0] cruise_speed;
    logic [SPEED_BITS-1:0] steer_limit;
    logic [GAIN_BITS-1:0]  gain_side_tenths;
    logic [GAIN_BITS-1:0]  gain_diag_tenths;
    logic [GAIN_BITS-1:0]  gain_front_tenths;
  } cfg_t;

  // decisions taken on the front readings and the clear request when a word is accepted
  typedef struct packed {
    logic clear;
    logic hit;
    logic right_more;
  } front_flags_t;

endpackage

// ===== rtl/oas_cfg_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oas_cfg_regs
// APB register file holding threshold, speeds and gains
// ---------------------------------------------------------------------------
module oas_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [oas_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [oas_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [oas_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready,
  output oas_pkg::cfg_t                     cfg
);
  import oas_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detect_threshold  <= DETECT_THRESHOLD_RST;
      cfg.cruise_speed      <= CRUISE_SPEED_RST;
      cfg.steer_limit       <= STEER_LIMIT_RST;
      cfg.gain_side_tenths  <= GAIN_SIDE_RST;
      cfg.gain_diag_tenths  <= GAIN_DIAG_RST;
      cfg.gain_front_tenths <= GAIN_FRONT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DETECT_THRESHOLD: cfg.detect_threshold  <= pwdata[FIELD_BITS-1:0];
        REG_CRUISE_SPEED:     cfg.cruise_speed      <= pwdata[SPEED_BITS-1:0];
        REG_STEER_LIMIT:      cfg.steer_limit       <= pwdata[SPEED_BITS-1:0];
        REG_GAIN_SIDE:        cfg.gain_side_tenths  <= pwdata[GAIN_BITS-1:0];
        REG_GAIN_DIAG:        cfg.gain_diag_tenths  <= pwdata[GAIN_BITS-1:0];
        REG_GAIN_FRONT:       cfg.gain_front_tenths <= pwdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DETECT_THRESHOLD: prdata = APB_DATA_BITS'(cfg.detect_threshold);
      REG_CRUISE_SPEED:     prdata = APB_DATA_BITS'(cfg.cruise_speed);
      REG_STEER_LIMIT:      prdata = APB_DATA_BITS'(cfg.steer_limit);
      REG_GAIN_SIDE:        prdata = APB_DATA_BITS'(cfg.gain_side_tenths);
      REG_GAIN_DIAG:        prdata = APB_DATA_BITS'(cfg.gain_diag_tenths);
      REG_GAIN_FRONT:       prdata = APB_DATA_BITS'(cfg.gain_front_tenths);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== rtl/oas_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oas_front
// Input register: gain products, obstacle detect and side compare
// ---------------------------------------------------------------------------
module oas_front #(
  parameter int SENSOR_BITS = oas_pkg::SENSOR_BITS_DEF,
  parameter int PROD_BITS   = SENSOR_BITS + oas_pkg::GAIN_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  oas_pkg::cfg_t             cfg,
  input  logic                      sensor_valid,
  output logic                      sensor_stall,
  input  oas_pkg::sensor_word_t     sensor_word,
  input  logic                      take,
  output logic                      held_valid,
  output oas_pkg::front_flags_t     held_flags,
  output logic [2:0][PROD_BITS-1:0] prod_right,
  output logic [2:0][PROD_BITS-1:0] prod_left
);
  import oas_pkg::*;

  localparam int CMP_BITS = (SENSOR_BITS > FIELD_BITS) ? SENSOR_BITS : FIELD_BITS;

  logic [SENSOR_BITS-1:0] rf, rd, rs, ls, ld, lf;
  logic [CMP_BITS-1:0]    rf_w, rd_w, ld_w, lf_w, thr_w;
  logic [SENSOR_BITS:0]   right_pair, left_pair;
  logic                   accept;
  front_flags_t           flags_next;
  logic [2:0][PROD_BITS-1:0] prod_right_next, prod_left_next;

  assign rf = SENSOR_BITS'(sensor_word.right_front);
  assign rd = SENSOR_BITS'(sensor_word.right_diag);
  assign rs = SENSOR_BITS'(sensor_word.right_side);
  assign ls = SENSOR_BITS'(sensor_word.left_side);
  assign ld = SENSOR_BITS'(sensor_word.left_diag);
  assign lf = SENSOR_BITS'(sensor_word.left_front);

  assign rf_w  = CMP_BITS'(rf);
  assign rd_w  = CMP_BITS'(rd);
  assign ld_w  = CMP_BITS'(ld);
  assign lf_w  = CMP_BITS'(lf);
  assign thr_w = CMP_BITS'(cfg.detect_threshold);

  assign right_pair = (SENSOR_BITS+1)'(rf) + (SENSOR_BITS+1)'(rd);
  assign left_pair  = (SENSOR_BITS+1)'(ld) + (SENSOR_BITS+1)'(lf);

  // any front reading above threshold is the same as the peak above it
  assign flags_next.clear      = sensor_word.clear_request;
  assign flags_next.hit        = (rf_w > thr_w) | (rd_w > thr_w) |
                                 (ld_w > thr_w) | (lf_w > thr_w);
  assign flags_next.right_more = right_pair > left_pair;

  assign prod_right_next[TERM_SIDE]  = PROD_BITS'(cfg.gain_side_tenths)  * PROD_BITS'(rs);
  assign prod_right_next[TERM_DIAG]  = PROD_BITS'(cfg.gain_diag_tenths)  * PROD_BITS'(rd);
  assign prod_right_next[TERM_FRONT] = PROD_BITS'(cfg.gain_front_tenths) * PROD_BITS'(rf);
  assign prod_left_next[TERM_SIDE]   = PROD_BITS'(cfg.gain_side_tenths)  * PROD_BITS'(ls);
  assign prod_left_next[TERM_DIAG]   = PROD_BITS'(cfg.gain_diag_tenths)  * PROD_BITS'(ld);
  assign prod_left_next[TERM_FRONT]  = PROD_BITS'(cfg.gain_front_tenths) * PROD_BITS'(lf);

  assign sensor_stall = held_valid & ~take;
  assign accept       = sensor_valid & ~sensor_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= accept | (held_valid & ~take);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_flags <= flags_next;
      prod_right <= prod_right_next;
      prod_left  <= prod_left_next;
    end
  end

endmodule

// ===== rtl/oas_steer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oas_steer
// Avoidance state, steering delta and wheel speed result register
// ---------------------------------------------------------------------------
module oas_steer #(
  parameter int SENSOR_BITS = oas_pkg::SENSOR_BITS_DEF,
  parameter int PROD_BITS   = SENSOR_BITS + oas_pkg::GAIN_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  oas_pkg::cfg_t             cfg,
  input  logic                      held_valid,
  input  oas_pkg::front_flags_t     held_flags,
  input  logic [2:0][PROD_BITS-1:0] prod_right,
  input  logic [2:0][PROD_BITS-1:0] prod_left,
  output logic                      take,
  output logic                      steer_valid,
  input  logic                      steer_stall,
  output oas_pkg::steer_word_t      steer_word
);
  import oas_pkg::*;

  // x / 10 as (x * RECIP) >> SHIFT, exact over the whole product range
  localparam int          SHIFT     = PROD_BITS + 4;
  localparam int          WIDE_BITS = PROD_BITS + SHIFT;
  localparam longint      RECIP     = ((64'sd1 <<< SHIFT) + 64'sd9) / 64'sd10;
  localparam int          TERM_BITS = SENSOR_BITS + 2;
  localparam int          SUM_BITS  = TERM_BITS + 2;

  logic                  active;
  logic [1:0]            side;
  logic                  active_base, active_next;
  logic [1:0]            side_base, side_next;
  logic [2:0][PROD_BITS-1:0] prod_sel;
  logic [2:0][WIDE_BITS-1:0] scaled;
  logic [2:0][TERM_BITS-1:0] term;
  logic [SUM_BITS-1:0]   mag_sum;
  logic [SPEED_BITS-1:0] mag;
  logic [FIELD_BITS-1:0] wheel_plus, wheel_minus;
  steer_word_t           word_next;

  assign take = held_valid & (~steer_valid | ~steer_stall);

  always_comb begin
    active_base = held_flags.clear ? 1'b0 : active;
    side_base   = held_flags.clear ? SIDE_NONE : side;
    active_next = active_base | held_flags.hit;
    if (active_next && side_base == SIDE_NONE) begin
      side_next = held_flags.right_more ? SIDE_RIGHT : SIDE_LEFT;
    end else begin
      side_next = side_base;
    end
  end

  assign prod_sel = (side_next == SIDE_LEFT) ? prod_left : prod_right;

  for (genvar i = 0; i < 3; i++) begin : g_term
    assign scaled[i] = WIDE_BITS'(prod_sel[i]) * WIDE_BITS'(RECIP);
    assign term[i]   = scaled[i][SHIFT +: TERM_BITS];
  end

  assign mag_sum = SUM_BITS'(term[TERM_SIDE]) + SUM_BITS'(term[TERM_DIAG]) +
                   SUM_BITS'(term[TERM_FRONT]);

  always_comb begin
    if (!active_next) begin
      mag = '0;
    end else if (mag_sum > SUM_BITS'(cfg.steer_limit)) begin
      mag = cfg.steer_limit;
    end else begin
      mag = mag_sum[SPEED_BITS-1:0];
    end
  end

  assign wheel_plus  = FIELD_BITS'(cfg.cruise_speed) + FIELD_BITS'(mag);
  assign wheel_minus = FIELD_BITS'(cfg.cruise_speed) - FIELD_BITS'(mag);

  // left obstacle turns the delta around
  always_comb begin
    if (side_next == SIDE_LEFT) begin
      word_next.left_wheel  = wheel_plus;
      word_next.right_wheel = wheel_minus;
    end else begin
      word_next.left_wheel  = wheel_minus;
      word_next.right_wheel = wheel_plus;
    end
    word_next.avoiding      = active_next;
    word_next.obstacle_side = side_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      side        <= SIDE_NONE;
      steer_valid <= 1'b0;
    end else if (take) begin
      active      <= active_next;
      side        <= side_next;
      steer_valid <= 1'b1;
    end else if (!steer_stall) begin
      steer_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      steer_word <= word_next;
    end
  end

endmodule

// ===== rtl/obstacle_avoidance_steering_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obstacle_avoidance_steering_unit
// Proximity driven steering: detects a front obstacle, latches its side and
// turns the wheel speeds away from it
// ---------------------------------------------------------------------------
//   channel   handshake                    payload
//   sensor    sensor_valid / sensor_stall  sensor_word  (six readings, clear)
//   steer     steer_valid / steer_stall    steer_word   (wheels, flags)
//   config    APB psel/penable/pwrite      paddr, pwdata, prdata
//
// one word per cycle while the result is not stalled; the input register (gain
// products) loads at acceptance and the result register loads when the word
// is taken from it
// the avoidance state updates as a word moves into the result register
// reset clears valid flags, avoidance state and config registers to defaults
// a stalled result holds; sensor_stall rises in the same cycle only when the
// input register is also full
// ---------------------------------------------------------------------------
module obstacle_avoidance_steering_unit #(
  parameter int SENSOR_BITS = oas_pkg::SENSOR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sensor_valid,
  output logic                              sensor_stall,
  input  oas_pkg::sensor_word_t             sensor_word,
  output logic                              steer_valid,
  input  logic                              steer_stall,
  output oas_pkg::steer_word_t              steer_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [oas_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [oas_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [oas_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import oas_pkg::*;

  localparam int PROD_BITS = SENSOR_BITS + GAIN_BITS;

  cfg_t                      cfg;
  logic                      take;
  logic                      held_valid;
  front_flags_t              held_flags;
  logic [2:0][PROD_BITS-1:0] prod_right;
  logic [2:0][PROD_BITS-1:0] prod_left;

  oas_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  oas_front #(
    .SENSOR_BITS (SENSOR_BITS),
    .PROD_BITS   (PROD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sensor_valid (sensor_valid),
    .sensor_stall (sensor_stall),
    .sensor_word  (sensor_word),
    .take         (take),
    .held_valid   (held_valid),
    .held_flags   (held_flags),
    .prod_right   (prod_right),
    .prod_left    (prod_left)
  );

  oas_steer #(
    .SENSOR_BITS (SENSOR_BITS),
    .PROD_BITS   (PROD_BITS)
  ) u_steer (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .held_valid  (held_valid),
    .held_flags  (held_flags),
    .prod_right  (prod_right),
    .prod_left   (prod_left),
    .take        (take),
    .steer_valid (steer_valid),
    .steer_stall (steer_stall),
    .steer_word  (steer_word)
  );

endmodule

// ===== rtl/oas_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oas_checker
// Port level checks on the steering unit, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module oas_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  sensor_stall,
  input logic                  steer_valid,
  input logic                  steer_stall,
  input oas_pkg::steer_word_t  steer_word
);
  import oas_pkg::*;

  // a held result word stays put
  `ASSERT_NEXT(a_hold, clk, rst, steer_valid && steer_stall, steer_valid && $stable(steer_word))

  // side is latched exactly while avoiding
  `ASSERT_IMPL(a_side, clk, rst, steer_valid, steer_word.avoiding ? (steer_word.obstacle_side == SIDE_LEFT || steer_word.obstacle_side == SIDE_RIGHT) : (steer_word.obstacle_side == SIDE_NONE))

  // no steering while not avoiding
  `ASSERT_IMPL(a_straight, clk, rst, steer_valid && !steer_word.avoiding, steer_word.left_wheel == steer_word.right_wheel)

  // input only backs up behind a stalled result
  `ASSERT_IMPL(a_stall_cause, clk, rst, sensor_stall, steer_valid && steer_stall)

  // reset leaves no result pending
  `ASSERT_IMPL(a_rst_empty, clk, rst, $past(rst), !steer_valid)

endmodule

bind obstacle_avoidance_steering_unit oas_checker u_oas_checker (
  .clk          (clk),
  .rst          (rst),
  .sensor_stall (sensor_stall),
  .steer_valid  (steer_valid),
  .steer_stall  (steer_stall),
  .steer_word   (steer_word)
);

// ===== sim/obstacle_avoidance_steering_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// obstacle_avoidance_steering_unit_tb
// Self-checking bench for the steering unit: a wheel speed tracker predicts
// every steer word from the sensor words and register settings and compares
// it with the block's output while both channels idle and stall at random
// ---------------------------------------------------------------------------
module obstacle_avoidance_steering_unit_tb;
  import oas_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd6;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 242;
  localparam int REPORT_CAP = 100;

  // tracks avoidance state and settings, holds the steer words still to come
  class wheel_speed_tracker;
    cfg_t regs;
    logic avoid_active;
    logic [1:0] side;
    steer_word_t expected_steer[$];
    int mismatch_count;

    function new();
      regs.detect_threshold = DETECT_THRESHOLD_RST;
      regs.cruise_speed = CRUISE_SPEED_RST;
      regs.steer_limit = STEER_LIMIT_RST;
      regs.gain_side_tenths = GAIN_SIDE_RST;
      regs.gain_diag_tenths = GAIN_DIAG_RST;
      regs.gain_front_tenths = GAIN_FRONT_RST;
      avoid_active = 1'b0;
      side = SIDE_NONE;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_DETECT_THRESHOLD: regs.detect_threshold = data[FIELD_BITS-1:0];
        REG_CRUISE_SPEED: regs.cruise_speed = data[SPEED_BITS-1:0];
        REG_STEER_LIMIT: regs.steer_limit = data[SPEED_BITS-1:0];
        REG_GAIN_SIDE: regs.gain_side_tenths = data[GAIN_BITS-1:0];
        REG_GAIN_DIAG: regs.gain_diag_tenths = data[GAIN_BITS-1:0];
        REG_GAIN_FRONT: regs.gain_front_tenths = data[GAIN_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int tenths(logic [GAIN_BITS-1:0] gain, logic [FIELD_BITS-1:0] reading);
      return (int'(gain) * int'(reading)) / 10;
    endfunction

    function void note_sensor_word(sensor_word_t w);
      steer_word_t exp_w;
      int peak;
      int delta;
      int lim;
      int lw;
      int rw;
      if (w.clear_request) begin
        avoid_active = 1'b0;
        side = SIDE_NONE;
      end
      peak = int'(w.right_front);
      if (int'(w.right_diag) > peak) peak = int'(w.right_diag);
      if (int'(w.left_diag) > peak) peak = int'(w.left_diag);
      if (int'(w.left_front) > peak) peak = int'(w.left_front);
      if (peak > int'(regs.detect_threshold)) avoid_active = 1'b1;
      // side is latched once per episode, a tie goes left
      if (avoid_active && side == SIDE_NONE) begin
        side = (int'(w.right_front) + int'(w.right_diag) >
                int'(w.left_diag) + int'(w.left_front)) ? SIDE_RIGHT : SIDE_LEFT;
      end
      delta = 0;
      if (avoid_active) begin
        lim = int'(regs.steer_limit);
        if (side == SIDE_LEFT) begin
          delta = -(tenths(regs.gain_side_tenths, w.left_side)
                  + tenths(regs.gain_diag_tenths, w.left_diag)
                  + tenths(regs.gain_front_tenths, w.left_front));
        end else begin
          delta = tenths(regs.gain_side_tenths, w.right_side)
                + tenths(regs.gain_diag_tenths, w.right_diag)
                + tenths(regs.gain_front_tenths, w.right_front);
        end
        if (delta > lim) delta = lim;
        if (delta < -lim) delta = -lim;
      end
      lw = int'(regs.cruise_speed) - delta;
      rw = int'(regs.cruise_speed) + delta;
      exp_w.left_wheel = lw[FIELD_BITS-1:0];
      exp_w.right_wheel = rw[FIELD_BITS-1:0];
      exp_w.avoiding = avoid_active;
      exp_w.obstacle_side = side;
      expected_steer.push_back(exp_w);
    endfunction

    function int pending();
      return expected_steer.size();
    endfunction

    function void report(string what, int exp_v, int got_v);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
        $display("%0t %s expected %0d got %0d", $time, what, exp_v, got_v);
    endfunction

    function void check_steer_word(steer_word_t got);
      steer_word_t exp_w;
      if (expected_steer.size() == 0) begin
        report("unexpected steer word, left_wheel", 0, int'(got.left_wheel));
        return;
      end
      exp_w = expected_steer.pop_front();
      if (got.left_wheel !== exp_w.left_wheel)
        report("left_wheel", int'(exp_w.left_wheel), int'(got.left_wheel));
      if (got.right_wheel !== exp_w.right_wheel)
        report("right_wheel", int'(exp_w.right_wheel), int'(got.right_wheel));
      if (got.avoiding !== exp_w.avoiding)
        report("avoiding", int'(exp_w.avoiding), int'(got.avoiding));
      if (got.obstacle_side !== exp_w.obstacle_side)
        report("obstacle_side", int'(exp_w.obstacle_side), int'(got.obstacle_side));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic sensor_valid;
  logic sensor_stall;
  sensor_word_t sensor_word;
  logic steer_valid;
  logic steer_stall;
  steer_word_t steer_word;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  wheel_speed_tracker sb = new();
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;

  obstacle_avoidance_steering_unit uut (
    .clk(clk),
    .rst(rst),
    .sensor_valid(sensor_valid),
    .sensor_stall(sensor_stall),
    .sensor_word(sensor_word),
    .steer_valid(steer_valid),
    .steer_stall(steer_stall),
    .steer_word(steer_word),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_reading(int thr);
    int v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 4095;
      2, 3: v = $urandom_range(0, 4095);
      4, 5: v = thr + $urandom_range(0, 6) - 3;
      default: v = $urandom_range(0, thr);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[FIELD_BITS-1:0];
  endfunction

  function automatic sensor_word_t readings(int rf, int rd, int rs, int ls, int ld,
                                            int lf, bit clr);
    sensor_word_t w;
    w.right_front = rf[FIELD_BITS-1:0];
    w.right_diag = rd[FIELD_BITS-1:0];
    w.right_side = rs[FIELD_BITS-1:0];
    w.left_side = ls[FIELD_BITS-1:0];
    w.left_diag = ld[FIELD_BITS-1:0];
    w.left_front = lf[FIELD_BITS-1:0];
    w.clear_request = clr;
    return w;
  endfunction

  function automatic sensor_word_t random_sensor_word();
    int thr;
    thr = int'(sb.regs.detect_threshold);
    return readings(pick_reading(thr), pick_reading(thr), pick_reading(thr),
                    pick_reading(thr), pick_reading(thr), pick_reading(thr),
                    $urandom_range(0, 9) == 0);
  endfunction

  task automatic send_word(input sensor_word_t w, input int gap);
    if (gap > 0) begin
      sensor_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sensor_valid <= 1'b1;
    sensor_word <= w;
    do @(posedge clk); while (sensor_stall);
    sb.note_sensor_word(w);
  endtask

  task automatic drain();
    sensor_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // junk above the register width must be dropped by the block
  task automatic load_settings(input int thr, input int cruise, input int limit,
                               input int gs, input int gd, input int gf,
                               input bit junk);
    logic [31:0] hi;
    hi = junk ? $urandom() : 32'd0;
    write_reg(REG_DETECT_THRESHOLD, (hi << FIELD_BITS) | thr);
    write_reg(REG_CRUISE_SPEED, (hi << SPEED_BITS) | cruise);
    write_reg(REG_STEER_LIMIT, (hi << SPEED_BITS) | limit);
    write_reg(REG_GAIN_SIDE, (hi << GAIN_BITS) | gs);
    write_reg(REG_GAIN_DIAG, (hi << GAIN_BITS) | gd);
    write_reg(REG_GAIN_FRONT, (hi << GAIN_BITS) | gf);
  endtask

  // receiver: random stall runs, or one long hold when asked
  initial begin
    int n;
    steer_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        steer_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        steer_stall <= 1'b0;
      end else if (!stalls_on) begin
        steer_stall <= 1'b0;
      end else begin
        n = pick_idle();
        if (n == 0) begin
          steer_stall <= 1'b0;
        end else begin
          steer_stall <= 1'b1;
          repeat (n) @(posedge clk);
          steer_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && steer_valid && !steer_stall) sb.check_steer_word(steer_word);
  end

  initial begin
    int gap;
    rst <= 1'b1;
    sensor_valid <= 1'b0;
    sensor_word <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset settings
    send_word(readings(0, 0, 0, 0, 0, 0, 0), pick_idle());
    send_word(readings(100, 100, 0, 0, 100, 100, 0), pick_idle());
    send_word(readings(0, 0, 4095, 4095, 0, 0, 0), pick_idle());
    send_word(readings(101, 0, 0, 0, 0, 0, 1), pick_idle());
    send_word(readings(0, 0, 300, 4095, 4095, 4095, 0), pick_idle());
    send_word(readings(0, 0, 0, 0, 0, 0, 1), pick_idle());
    send_word(readings(200, 0, 0, 0, 200, 0, 1), pick_idle());
    send_word(readings(4095, 4095, 4095, 0, 0, 0, 1), pick_idle());
    send_word(readings(0, 0, 0, 4095, 4095, 4095, 1), pick_idle());
    send_word(readings(4095, 4095, 4095, 4095, 4095, 4095, 1), pick_idle());
    send_word(readings(0, 101, 50, 0, 0, 0, 1), pick_idle());
    send_word(readings(0, 0, 0, 50, 101, 0, 1), pick_idle());
    send_word(readings(4095, 4095, 4095, 4095, 4095, 4095, 0), pick_idle());
    send_word(readings(0, 0, 0, 0, 0, 0, 1), pick_idle());
    send_word(readings(40, 30, 20, 10, 0, 5, 0), pick_idle());

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: load_settings(0, 0, 0, 0, 0, 0, 1'b0);
        1: load_settings(4095, 1023, 1023, 31, 31, 31, 1'b0);
        2: load_settings(0, 1023, 1023, 31, 31, 31, 1'b0);
        3: load_settings(100, 150, 600, 2, 9, 12, 1'b1);
        default: load_settings($urandom_range(0, 1200), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 31),
                               $urandom_range(0, 31), $urandom_range(0, 31), 1'b1);
      endcase
      if (p == 4) write_reg(REG_UNMAPPED, $urandom());
      stalls_on = (p != 1 && p != 5);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (p == 2 && i == 100) hold_req = 1'b1;
        // in phase 4, at word 120, the sender waits for every steer word before going on
        if (p == 4 && i == 120) drain();
        if (p == 5 || (p == 2 && i >= 100 && i < 140)) gap = 0;
        else if (p == 6) gap = pick_idle() + 1;
        else gap = pick_idle();
        send_word(random_sensor_word(), gap);
      end
    end

    sensor_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
